// ----- hdl/density_block_unitary_update_assert.svh -----
// Assertion macros for the density block unitary update RTL.
// Used by the top level; no other dependencies.
`ifndef DENSITY_BLOCK_UNITARY_UPDATE_ASSERT_SVH
`define DENSITY_BLOCK_UNITARY_UPDATE_ASSERT_SVH
`ifndef SYNTHESIS
`define DBU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DBU_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `DBU_ASSERT(lbl, clk, rst_n, !(cond), msg)
`else
`define DBU_ASSERT(lbl, clk, rst_n, prop, msg)
`define DBU_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ----- hdl/dbu_pkg.sv -----
// Shared types and constants for the density block unitary update.
// No dependencies.
package dbu_pkg;

  localparam int unsigned DataW   = 16;
  localparam int unsigned CoefW   = DataW + 1;
  localparam int unsigned ProdW   = DataW + CoefW;
  localparam int unsigned AccW    = ProdW + 3;
  localparam int unsigned FracW   = 14;
  localparam int unsigned CfgIdxW = 3;

  localparam logic signed [DataW-1:0] OneQ  = DataW'(2 ** FracW);
  localparam logic signed [DataW-1:0] ZeroQ = '0;

  typedef enum logic [CfgIdxW-1:0] {
    CfgU00Re, CfgU00Im, CfgU01Re, CfgU01Im,
    CfgU10Re, CfgU10Im, CfgU11Re, CfgU11Im
  } cfg_reg_e;

  typedef struct packed {
    logic signed [DataW-1:0] re;
    logic signed [DataW-1:0] im;
  } cplx_t;

  typedef struct packed {
    logic signed [CoefW-1:0] re;
    logic signed [CoefW-1:0] im;
  } coef_t;

  typedef cplx_t [1:0][1:0] blk_t;
  typedef coef_t [1:0][1:0] mat_t;

  typedef struct packed {
    logic active;
    logic tag;
  } pass_ctl_t;

  typedef struct packed {
    logic signed [DataW-1:0] v00_re;
    logic signed [DataW-1:0] v00_im;
    logic signed [DataW-1:0] v01_re;
    logic signed [DataW-1:0] v01_im;
    logic signed [DataW-1:0] v10_re;
    logic signed [DataW-1:0] v10_im;
    logic signed [DataW-1:0] v11_re;
    logic signed [DataW-1:0] v11_im;
    logic                    row_active;
    logic                    col_active;
  } in_t;

  typedef struct packed {
    logic signed [DataW-1:0] w00_re;
    logic signed [DataW-1:0] w00_im;
    logic signed [DataW-1:0] w01_re;
    logic signed [DataW-1:0] w01_im;
    logic signed [DataW-1:0] w10_re;
    logic signed [DataW-1:0] w10_im;
    logic signed [DataW-1:0] w11_re;
    logic signed [DataW-1:0] w11_im;
  } out_t;

endpackage

// ----- hdl/dbu_cfg_regs.sv -----
// Matrix register file for the unitary; provides U and its conjugate.
// Depends on dbu_pkg.
module dbu_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dbu_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dbu_pkg::DataW-1:0]     cfg_wdata_i,
  output dbu_pkg::mat_t                 mat_l_o,
  output dbu_pkg::mat_t                 mat_r_o
);

  dbu_pkg::cplx_t [1:0][1:0] u_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_q[0][0] <= '{re: dbu_pkg::OneQ,  im: dbu_pkg::ZeroQ};
      u_q[0][1] <= '{re: dbu_pkg::ZeroQ, im: dbu_pkg::ZeroQ};
      u_q[1][0] <= '{re: dbu_pkg::ZeroQ, im: dbu_pkg::ZeroQ};
      u_q[1][1] <= '{re: dbu_pkg::OneQ,  im: dbu_pkg::ZeroQ};
    end else if (cfg_we_i) begin
      unique case (dbu_pkg::cfg_reg_e'(cfg_idx_i))
        dbu_pkg::CfgU00Re: u_q[0][0].re <= cfg_wdata_i;
        dbu_pkg::CfgU00Im: u_q[0][0].im <= cfg_wdata_i;
        dbu_pkg::CfgU01Re: u_q[0][1].re <= cfg_wdata_i;
        dbu_pkg::CfgU01Im: u_q[0][1].im <= cfg_wdata_i;
        dbu_pkg::CfgU10Re: u_q[1][0].re <= cfg_wdata_i;
        dbu_pkg::CfgU10Im: u_q[1][0].im <= cfg_wdata_i;
        dbu_pkg::CfgU11Re: u_q[1][1].re <= cfg_wdata_i;
        dbu_pkg::CfgU11Im: u_q[1][1].im <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Conjugate needs one extra bit so the most negative imaginary part negates cleanly.
  always_comb begin
    for (int r = 0; r < 2; r++) begin
      for (int c = 0; c < 2; c++) begin
        mat_l_o[r][c].re = dbu_pkg::CoefW'(u_q[r][c].re);
        mat_l_o[r][c].im = dbu_pkg::CoefW'(u_q[r][c].im);
        mat_r_o[r][c].re = dbu_pkg::CoefW'(u_q[r][c].re);
        mat_r_o[r][c].im = -dbu_pkg::CoefW'(u_q[r][c].im);
      end
    end
  end

endmodule

// ----- hdl/dbu_cmul_pass.sv -----
// One complex 2x2 matrix product pass, out = M * N, with bypass to N.
// Two stages: product registers, then sum, round and saturate. Depends on dbu_pkg.
module dbu_cmul_pass (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dbu_pkg::mat_t      coef_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dbu_pkg::blk_t      data_i,
  input  dbu_pkg::pass_ctl_t ctl_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dbu_pkg::blk_t      data_o,
  output dbu_pkg::pass_ctl_t ctl_o
);

  localparam int unsigned ShrW = dbu_pkg::AccW - dbu_pkg::FracW;
  localparam logic signed [dbu_pkg::AccW-1:0] RoundHalf =
    dbu_pkg::AccW'(2 ** (dbu_pkg::FracW - 1));
  localparam logic signed [ShrW-1:0] SatMax = ShrW'(2 ** (dbu_pkg::DataW - 1) - 1);
  localparam logic signed [ShrW-1:0] SatMin = -ShrW'(2 ** (dbu_pkg::DataW - 1));

  function automatic logic signed [dbu_pkg::DataW-1:0] round_sat(
    input logic signed [dbu_pkg::AccW-1:0] acc
  );
    logic signed [dbu_pkg::AccW-1:0] biased;
    logic signed [ShrW-1:0]          shr;
    logic signed [dbu_pkg::DataW-1:0] res;
    biased = acc + RoundHalf;
    shr    = biased[dbu_pkg::AccW-1:dbu_pkg::FracW];
    if (shr > SatMax) begin
      res = SatMax[dbu_pkg::DataW-1:0];
    end else if (shr < SatMin) begin
      res = SatMin[dbu_pkg::DataW-1:0];
    end else begin
      res = shr[dbu_pkg::DataW-1:0];
    end
    return res;
  endfunction

  logic               vld_a_q, vld_b_q;
  logic               en_a, en_b;
  dbu_pkg::pass_ctl_t ctl_a_q, ctl_b_q;
  dbu_pkg::blk_t      byp_a_q, res_b_q, res_b_d;

  logic signed [dbu_pkg::ProdW-1:0] p_rr_d [2][2][2];
  logic signed [dbu_pkg::ProdW-1:0] p_ii_d [2][2][2];
  logic signed [dbu_pkg::ProdW-1:0] p_ri_d [2][2][2];
  logic signed [dbu_pkg::ProdW-1:0] p_ir_d [2][2][2];
  logic signed [dbu_pkg::ProdW-1:0] p_rr_q [2][2][2];
  logic signed [dbu_pkg::ProdW-1:0] p_ii_q [2][2][2];
  logic signed [dbu_pkg::ProdW-1:0] p_ri_q [2][2][2];
  logic signed [dbu_pkg::ProdW-1:0] p_ir_q [2][2][2];

  assign en_b       = !vld_b_q || out_ready_i;
  assign en_a       = !vld_a_q || en_b;
  assign in_ready_o = en_a;

  always_comb begin
    for (int r = 0; r < 2; r++) begin
      for (int c = 0; c < 2; c++) begin
        for (int k = 0; k < 2; k++) begin
          p_rr_d[r][c][k] = $signed(coef_i[r][k].re) * $signed(data_i[k][c].re);
          p_ii_d[r][c][k] = $signed(coef_i[r][k].im) * $signed(data_i[k][c].im);
          p_ri_d[r][c][k] = $signed(coef_i[r][k].re) * $signed(data_i[k][c].im);
          p_ir_d[r][c][k] = $signed(coef_i[r][k].im) * $signed(data_i[k][c].re);
        end
      end
    end
  end

  always_comb begin
    logic signed [dbu_pkg::AccW-1:0] acc_re, acc_im;
    for (int r = 0; r < 2; r++) begin
      for (int c = 0; c < 2; c++) begin
        acc_re = dbu_pkg::AccW'(p_rr_q[r][c][0]) - dbu_pkg::AccW'(p_ii_q[r][c][0])
               + dbu_pkg::AccW'(p_rr_q[r][c][1]) - dbu_pkg::AccW'(p_ii_q[r][c][1]);
        acc_im = dbu_pkg::AccW'(p_ri_q[r][c][0]) + dbu_pkg::AccW'(p_ir_q[r][c][0])
               + dbu_pkg::AccW'(p_ri_q[r][c][1]) + dbu_pkg::AccW'(p_ir_q[r][c][1]);
        if (ctl_a_q.active) begin
          res_b_d[r][c].re = round_sat(acc_re);
          res_b_d[r][c].im = round_sat(acc_im);
        end else begin
          res_b_d[r][c] = byp_a_q[r][c];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      if (en_a) begin
        vld_a_q <= in_valid_i;
      end
      if (en_b) begin
        vld_b_q <= vld_a_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && in_valid_i) begin
      ctl_a_q <= ctl_i;
      byp_a_q <= data_i;
      p_rr_q  <= p_rr_d;
      p_ii_q  <= p_ii_d;
      p_ri_q  <= p_ri_d;
      p_ir_q  <= p_ir_d;
    end
    if (en_b && vld_a_q) begin
      ctl_b_q <= ctl_a_q;
      res_b_q <= res_b_d;
    end
  end

  assign out_valid_o = vld_b_q;
  assign data_o      = res_b_q;
  assign ctl_o       = ctl_b_q;

endmodule

// ----- hdl/density_block_unitary_update.sv -----
// Top level of the density block unitary update: W = L * V * R on one 2x2 block.
// Depends on dbu_pkg, dbu_cfg_regs, dbu_cmul_pass and the assertion header.
//
//   channel  | signals                              | transfer
//   ---------+--------------------------------------+-----------------------------
//   cfg      | cfg_we_i, cfg_idx_i, cfg_wdata_i     | write when cfg_we_i is high
//   in       | in_valid_i, in_ready_o, in_data_i    | valid & ready at clk_i rise
//   out      | out_valid_o, out_ready_i, out_data_o | valid & ready at clk_i rise
//
// One transaction per cycle while the output is not stalled; out_valid_o rises once the
// input has passed four register stages (product, then sum/round/saturate, for each of the
// two passes), the first loaded at the edge that takes the input.
// Reset clears all stage valid bits and loads U with the identity.
// Each stage holds while the one after it is full and stalled; empty stages fill,
// so input is still taken while a finished result waits at the output.
`include "density_block_unitary_update_assert.svh"
module density_block_unitary_update (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dbu_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [dbu_pkg::DataW-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  dbu_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output dbu_pkg::out_t               out_data_o
);

  dbu_pkg::mat_t      mat_l, mat_r;
  dbu_pkg::blk_t      v_blk, t_blk, tt_blk, wt_blk;
  dbu_pkg::pass_ctl_t ctl_in, ctl_mid;
  logic               lft_vld, rgt_rdy;

  dbu_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mat_l_o     (mat_l),
    .mat_r_o     (mat_r)
  );

  assign v_blk[0][0] = '{re: in_data_i.v00_re, im: in_data_i.v00_im};
  assign v_blk[0][1] = '{re: in_data_i.v01_re, im: in_data_i.v01_im};
  assign v_blk[1][0] = '{re: in_data_i.v10_re, im: in_data_i.v10_im};
  assign v_blk[1][1] = '{re: in_data_i.v11_re, im: in_data_i.v11_im};
  assign ctl_in      = '{active: in_data_i.row_active, tag: in_data_i.col_active};

  dbu_cmul_pass u_pass_l (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_i      (mat_l),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_i      (v_blk),
    .ctl_i       (ctl_in),
    .out_valid_o (lft_vld),
    .out_ready_i (rgt_rdy),
    .data_o      (t_blk),
    .ctl_o       (ctl_mid)
  );

  // Right product runs transposed: W^T = conj(U) * T^T.
  always_comb begin
    for (int r = 0; r < 2; r++) begin
      for (int c = 0; c < 2; c++) begin
        tt_blk[c][r] = t_blk[r][c];
      end
    end
  end

  dbu_cmul_pass u_pass_r (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_i      (mat_r),
    .in_valid_i  (lft_vld),
    .in_ready_o  (rgt_rdy),
    .data_i      (tt_blk),
    .ctl_i       ('{active: ctl_mid.tag, tag: 1'b0}),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_o      (wt_blk),
    .ctl_o       ()
  );

  assign out_data_o = '{
    w00_re: wt_blk[0][0].re, w00_im: wt_blk[0][0].im,
    w01_re: wt_blk[1][0].re, w01_im: wt_blk[1][0].im,
    w10_re: wt_blk[0][1].re, w10_im: wt_blk[0][1].im,
    w11_re: wt_blk[1][1].re, w11_im: wt_blk[1][1].im
  };

  `DBU_ASSERT_NEVER(a_in_stall_needs_out_stall, clk_i, rst_ni, !in_ready_o && !(out_valid_o && !out_ready_i), "input stalled while output is not stalled")
  `DBU_ASSERT(a_mid_hold, clk_i, rst_ni, lft_vld && !rgt_rdy |=> lft_vld, "mid-pipeline transaction dropped during stall")
  `DBU_ASSERT_NEVER(a_out_needs_mid, clk_i, rst_ni, !rgt_rdy && !out_valid_o, "right pass stalled with empty output")

endmodule

// ----- verif/density_block_unitary_update_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for density_block_unitary_update: streams 2x2 blocks under several
// coefficient sets and checks every result against an in-bench fixed-point predictor.
// Depends on dbu_pkg and the density_block_unitary_update RTL.

class block_scoreboard;
  dbu_pkg::cplx_t coef [2][2];
  dbu_pkg::out_t  expected_q [$];
  int unsigned    n_checked;
  int unsigned    n_mismatch;

  function new();
    coef[0][0] = {dbu_pkg::OneQ, dbu_pkg::ZeroQ};
    coef[0][1] = {dbu_pkg::ZeroQ, dbu_pkg::ZeroQ};
    coef[1][0] = {dbu_pkg::ZeroQ, dbu_pkg::ZeroQ};
    coef[1][1] = {dbu_pkg::OneQ, dbu_pkg::ZeroQ};
    n_checked  = 0;
    n_mismatch = 0;
  endfunction

  function void set_coef(dbu_pkg::cfg_reg_e idx, logic signed [dbu_pkg::DataW-1:0] val);
    case (idx)
      dbu_pkg::CfgU00Re: coef[0][0].re = val;
      dbu_pkg::CfgU00Im: coef[0][0].im = val;
      dbu_pkg::CfgU01Re: coef[0][1].re = val;
      dbu_pkg::CfgU01Im: coef[0][1].im = val;
      dbu_pkg::CfgU10Re: coef[1][0].re = val;
      dbu_pkg::CfgU10Im: coef[1][0].im = val;
      dbu_pkg::CfgU11Re: coef[1][1].re = val;
      dbu_pkg::CfgU11Im: coef[1][1].im = val;
      default: ;
    endcase
  endfunction

  function longint mul(logic signed [dbu_pkg::DataW-1:0] a,
                       logic signed [dbu_pkg::DataW-1:0] b);
    return longint'(a) * longint'(b);
  endfunction

  function logic signed [dbu_pkg::DataW-1:0] round_q14(longint acc);
    longint r;
    r = (acc + 64'sd8192) >>> dbu_pkg::FracW;
    if (r > 32767) r = 32767;
    else if (r < -32768) r = -32768;
    return r[dbu_pkg::DataW-1:0];
  endfunction

  function dbu_pkg::out_t conjugate_block(dbu_pkg::in_t item);
    dbu_pkg::cplx_t v [2][2];
    dbu_pkg::cplx_t t [2][2];
    dbu_pkg::cplx_t w [2][2];
    longint         are;
    longint         aim;
    v[0][0] = {item.v00_re, item.v00_im};
    v[0][1] = {item.v01_re, item.v01_im};
    v[1][0] = {item.v10_re, item.v10_im};
    v[1][1] = {item.v11_re, item.v11_im};
    t = v;
    if (item.row_active) begin
      for (int r = 0; r < 2; r++)
        for (int c = 0; c < 2; c++) begin
          are = 0;
          aim = 0;
          for (int k = 0; k < 2; k++) begin
            are += mul(coef[r][k].re, v[k][c].re) - mul(coef[r][k].im, v[k][c].im);
            aim += mul(coef[r][k].re, v[k][c].im) + mul(coef[r][k].im, v[k][c].re);
          end
          t[r][c].re = round_q14(are);
          t[r][c].im = round_q14(aim);
        end
    end
    w = t;
    if (item.col_active) begin
      for (int r = 0; r < 2; r++)
        for (int c = 0; c < 2; c++) begin
          are = 0;
          aim = 0;
          for (int k = 0; k < 2; k++) begin
            are += mul(t[r][k].re, coef[c][k].re) + mul(t[r][k].im, coef[c][k].im);
            aim += mul(t[r][k].im, coef[c][k].re) - mul(t[r][k].re, coef[c][k].im);
          end
          w[r][c].re = round_q14(are);
          w[r][c].im = round_q14(aim);
        end
    end
    return {w[0][0], w[0][1], w[1][0], w[1][1]};
  endfunction

  function void note_block(dbu_pkg::in_t item);
    expected_q.push_back(conjugate_block(item));
  endfunction

  function int unsigned outstanding();
    return expected_q.size();
  endfunction

  function void check_block(dbu_pkg::out_t got);
    string                         names [8];
    logic [7:0][dbu_pkg::DataW-1:0] exp_f;
    logic [7:0][dbu_pkg::DataW-1:0] got_f;
    names = '{"w00_re", "w00_im", "w01_re", "w01_im", "w10_re", "w10_im", "w11_re", "w11_im"};
    if (expected_q.size() == 0) begin
      if (n_mismatch < 10) $display("ERROR: result with no pending block: %h", got);
      n_mismatch++;
      return;
    end
    exp_f = expected_q.pop_front();
    got_f = got;
    n_checked++;
    for (int i = 0; i < 8; i++) begin
      if (exp_f[7-i] !== got_f[7-i]) begin
        if (n_mismatch < 10)
          $display("ERROR: block %0d field %s expected %0d got %0d", n_checked, names[i],
                   $signed(exp_f[7-i]), $signed(got_f[7-i]));
        n_mismatch++;
      end
    end
  endfunction
endclass

module density_block_unitary_update_tb;
  localparam int unsigned Latency   = 4;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned NumSets   = 8;
  localparam int unsigned SetItems  = 190;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [dbu_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [dbu_pkg::DataW-1:0]   cfg_wdata_i;
  logic                        in_valid_i;
  logic                        in_ready_o;
  dbu_pkg::in_t                in_data_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  dbu_pkg::out_t               out_data_o;

  logic [31:0]                 cycle_cnt = '0;
  logic [1:0]                  stall_mode = '0;
  block_scoreboard             sb;

  density_block_unitary_update dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (cycle_cnt % 97 == 0) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0: out_ready_i <= 1'b1;
      2'd1: out_ready_i <= 1'($urandom_range(0, 1));
      2'd2: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= (cycle_cnt[3:0] >= 4'd12);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_block(out_data_o);
  end

  function automatic logic [dbu_pkg::DataW-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h4000;
      3: return 16'hc000;
      default: return dbu_pkg::DataW'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic dbu_pkg::in_t rand_block();
    dbu_pkg::in_t item;
    item.v00_re     = rand_sample();
    item.v00_im     = rand_sample();
    item.v01_re     = rand_sample();
    item.v01_im     = rand_sample();
    item.v10_re     = rand_sample();
    item.v10_im     = rand_sample();
    item.v11_re     = rand_sample();
    item.v11_im     = rand_sample();
    item.row_active = 1'($urandom_range(0, 1));
    item.col_active = 1'($urandom_range(0, 1));
    return item;
  endfunction

  task automatic send_block(input dbu_pkg::in_t item);
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_block(item);
  endtask

  task automatic pause_sender(input int unsigned n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic write_matrix(input logic [dbu_pkg::DataW-1:0] m [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= dbu_pkg::cfg_reg_e'(i);
      cfg_wdata_i <= m[i];
      sb.set_coef(dbu_pkg::cfg_reg_e'(i), m[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic directed_blocks();
    logic [dbu_pkg::DataW-1:0] pats [3];
    logic [1:0]                flags;
    pats = '{16'h7fff, 16'h8000, 16'h5555};
    for (int f = 0; f < 4; f++)
      for (int p = 0; p < 3; p++) begin
        flags = 2'(f);
        send_block({{4{pats[p], ~pats[p]}}, flags});
      end
  endtask

  task automatic stream_blocks(input int unsigned n);
    int unsigned left;
    int unsigned burst;
    int unsigned gap;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && left > 0; i++) begin
        send_block(rand_block());
        left--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) pause_sender(gap);
    end
  endtask

  initial begin
    logic [dbu_pkg::DataW-1:0] sets [NumSets][8];
    sb = new();
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= dbu_pkg::CfgU00Re;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_ready_i <= 1'b0;

    sets[0] = '{16'sd11585, 16'sd0, 16'sd11585, 16'sd0,
                16'sd11585, 16'sd0, -16'sd11585, 16'sd0};
    sets[1] = '{16'sd0, 16'sd0, 16'sd0, -16'sd16384,
                16'sd0, 16'sd16384, 16'sd0, 16'sd0};
    sets[2] = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0,
                16'sd0, 16'sd0, 16'sd11585, 16'sd11585};
    sets[3] = '{16'sd15137, 16'sd0, 16'sd0, -16'sd6270,
                16'sd0, -16'sd6270, 16'sd15137, 16'sd0};
    sets[4] = '{8{16'h7fff}};
    sets[5] = '{8{16'h8000}};
    for (int i = 0; i < 8; i++) sets[6][i] = dbu_pkg::DataW'($urandom_range(0, 65535));
    sets[7] = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0,
                16'sd0, 16'sd0, 16'sd16384, 16'sd0};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_blocks();
    stream_blocks(SetItems / 2);
    drain_results();
    stream_blocks(SetItems / 2);
    drain_results();

    for (int s = 0; s < NumSets; s++) begin
      write_matrix(sets[s]);
      if (s == 4) directed_blocks();
      stream_blocks(SetItems);
      drain_results();
    end

    $display("Checked %0d blocks across the reset matrix and %0d written coefficient sets,",
             sb.n_checked, NumSets);
    $display("all flag combinations, saturating matrices and random stalls: %0d mismatches",
             sb.n_mismatch);
    if (sb.n_mismatch == 0 && sb.outstanding() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
